FILE: rtl/tpbp_pkg.sv
// ----------------------------------------------------------------------------
// tpbp_pkg
// shared constants, codes and types of the trace packet bit packer
// ----------------------------------------------------------------------------
package tpbp_pkg;

   localparam int ADDR_WIDTH_DEF     = 32;
   localparam int CAUSE_WIDTH_DEF    = 5;
   localparam int LEN_FIELD_WIDTH    = 4;
   localparam int BRANCH_COUNT_WIDTH = 5;
   localparam int MAP_FULL           = 31;
   localparam int HDR_WIDTH          = LEN_FIELD_WIDTH + 4;
   localparam int BITCNT_W           = 7;
   localparam int MAX_BYTES          = 10;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_LEN  = 2'd1;
   localparam logic [1:0] ST_DIFF = 2'd2;

   localparam logic [1:0] FMT_FULL = 2'd0;
   localparam logic [1:0] FMT_DIFF = 2'd1;
   localparam logic [1:0] FMT_ADDR = 2'd2;
   localparam logic [1:0] FMT_SYNC = 2'd3;

   localparam logic [1:0] SUB_START = 2'd0;
   localparam logic [1:0] SUB_EXC   = 2'd1;

   localparam logic MODE_FLUSH = 1'b1;

   localparam logic CSR_WIDE_ADDR    = 1'b0;
   localparam logic CSR_COMPRESS_MAP = 1'b1;

   typedef struct packed {
      logic                flush;
      logic [1:0]          status;
      logic [BITCNT_W-1:0] bitcnt;
   } entry_ctl_type;

endpackage

FILE: rtl/tpbp_if.sv
// ----------------------------------------------------------------------------
// tpbp channel interfaces
// valid/ready channels for packet items and packed bytes
// ----------------------------------------------------------------------------
interface tpbp_req_if #(
   parameter int ADDR_WIDTH  = tpbp_pkg::ADDR_WIDTH_DEF,
   parameter int CAUSE_WIDTH = tpbp_pkg::CAUSE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [6:0]             declared_length;
   logic [1:0]             pkt_kind;
   logic [1:0]             format;
   logic [4:0]             branch_count;
   logic [30:0]            taken_map;
   logic [ADDR_WIDTH-1:0]  address;
   logic [1:0]             subformat;
   logic [2:0]             privilege;
   logic                   branch_taken;
   logic [CAUSE_WIDTH-1:0] exc_cause;
   logic                   is_interrupt;

   modport source (output valid, mode, declared_length, pkt_kind, format, branch_count,
                   taken_map, address, subformat, privilege, branch_taken, exc_cause,
                   is_interrupt, input ready);
   modport sink (input valid, mode, declared_length, pkt_kind, format, branch_count,
                 taken_map, address, subformat, privilege, branch_taken, exc_cause,
                 is_interrupt, output ready);
endinterface

interface tpbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic [1:0] status;

   modport source (output valid, out_byte, last, status, input ready);
   modport sink (input valid, out_byte, last, status, output ready);
endinterface

FILE: rtl/tpbp_front.sv
// ----------------------------------------------------------------------------
// tpbp_front
// classifies an item and builds its packet bits and bit count
// ----------------------------------------------------------------------------
module tpbp_front #(
   parameter int ADDR_WIDTH  = tpbp_pkg::ADDR_WIDTH_DEF,
   parameter int CAUSE_WIDTH = tpbp_pkg::CAUSE_WIDTH_DEF,
   parameter int PKT_W       = 44 + ADDR_WIDTH
) (
   tpbp_req_if.sink                 req,
   input  logic                     wide_addr,
   input  logic                     compress_map,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [PKT_W-1:0]         push_pkt,
   output tpbp_pkg::entry_ctl_type  push_ctl
);

   localparam int BW = tpbp_pkg::BITCNT_W;
   localparam int MAP_POS = tpbp_pkg::HDR_WIDTH + tpbp_pkg::BRANCH_COUNT_WIDTH;

   function automatic logic [5:0] addr_run(input logic [ADDR_WIDTH-1:0] v);
      logic [5:0] run;
      logic       done;
      run  = '0;
      done = 1'b0;
      for (int i = ADDR_WIDTH - 1; i >= 0; i--) begin
         if (!done && v[i] == v[ADDR_WIDTH-1]) begin
            run = run + 6'd1;
         end else begin
            done = 1'b1;
         end
      end
      return run;
   endfunction

   function automatic logic [4:0] map_run(input logic [30:0] v);
      logic [4:0] run;
      logic       done;
      run  = '0;
      done = 1'b0;
      for (int i = 30; i >= 0; i--) begin
         if (!done && v[i] == v[30]) begin
            run = run + 5'd1;
         end else begin
            done = 1'b1;
         end
      end
      return run;
   endfunction

   logic [3:0]     bytelen;
   logic           len_bad;
   logic [4:0]     ml;
   logic [30:0]    map_m;
   logic [BW-1:0]  addr_short;
   logic [BW-1:0]  addr_cnt;
   logic [BW-1:0]  map_cnt;
   logic [7:0]     hdr;
   logic [PKT_W-1:0] pkt;
   logic [BW-1:0]  bitcnt;

   assign len_bad = (req.declared_length < 7'd2) || (req.declared_length > 7'd122);
   assign bytelen = 4'((8'(req.declared_length) + 8'd5) >> 3);
   assign hdr     = {req.format, req.pkt_kind, bytelen};

   always_comb begin
      case (req.branch_count) inside
         5'd0:          ml = 5'd31;
         5'd1:          ml = 5'd1;
         [5'd2:5'd9]:   ml = 5'd9;
         [5'd10:5'd17]: ml = 5'd17;
         [5'd18:5'd25]: ml = 5'd25;
         default:       ml = 5'd31;
      endcase
   end

   assign map_m      = req.taken_map & 31'((32'd1 << ml) - 32'd1);
   assign addr_short = BW'(ADDR_WIDTH + 1) - BW'(addr_run(req.address));
   assign map_cnt    = BW'(32) - BW'(map_run(req.taken_map));

   always_comb begin
      pkt      = '0;
      pkt[7:0] = hdr;
      bitcnt   = BW'(tpbp_pkg::HDR_WIDTH);
      addr_cnt = addr_short;
      case (req.format)
         tpbp_pkg::FMT_FULL, tpbp_pkg::FMT_DIFF: begin
            pkt[12:8] = req.branch_count;
            pkt       = pkt | (PKT_W'(map_m) << MAP_POS);
            if (req.format == tpbp_pkg::FMT_FULL && wide_addr) begin
               addr_cnt = BW'(ADDR_WIDTH);
            end
            if (req.branch_count != 5'd0) begin
               pkt    = pkt | (PKT_W'(req.address) << (MAP_POS + int'(ml)));
               bitcnt = BW'(MAP_POS) + BW'(ml) + addr_cnt;
            end else if (compress_map) begin
               bitcnt = BW'(MAP_POS) + map_cnt;
            end else begin
               bitcnt = BW'(MAP_POS) + BW'(ml);
            end
         end
         tpbp_pkg::FMT_ADDR: begin
            pkt    = pkt | (PKT_W'(req.address) << tpbp_pkg::HDR_WIDTH);
            bitcnt = BW'(tpbp_pkg::HDR_WIDTH) + (wide_addr ? BW'(ADDR_WIDTH) : addr_short);
         end
         default: begin
            pkt[9:8]   = req.subformat;
            pkt[12:10] = req.privilege;
            bitcnt     = BW'(13);
            if (req.subformat == tpbp_pkg::SUB_START) begin
               pkt[13] = req.branch_taken;
               pkt     = pkt | (PKT_W'(req.address) << 14);
               bitcnt  = BW'(14 + ADDR_WIDTH);
            end else if (req.subformat == tpbp_pkg::SUB_EXC) begin
               pkt[13] = req.branch_taken;
               pkt     = pkt | (PKT_W'(req.address) << 14);
               pkt     = pkt | (PKT_W'(req.exc_cause) << (14 + ADDR_WIDTH));
               pkt     = pkt | (PKT_W'(req.is_interrupt) << (14 + ADDR_WIDTH + CAUSE_WIDTH));
               bitcnt  = BW'(15 + ADDR_WIDTH + CAUSE_WIDTH);
            end
         end
      endcase
   end

   always_comb begin
      push_ctl.flush  = (req.mode == tpbp_pkg::MODE_FLUSH);
      push_ctl.bitcnt = bitcnt;
      if (req.mode == tpbp_pkg::MODE_FLUSH) begin
         push_ctl.status = tpbp_pkg::ST_OK;
      end else if (len_bad) begin
         push_ctl.status = tpbp_pkg::ST_LEN;
      end else if (req.format == tpbp_pkg::FMT_DIFF && wide_addr) begin
         push_ctl.status = tpbp_pkg::ST_DIFF;
      end else begin
         push_ctl.status = tpbp_pkg::ST_OK;
      end
   end

   assign push_pkt   = pkt;
   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

FILE: rtl/tpbp_fifo.sv
// ----------------------------------------------------------------------------
// tpbp_fifo
// short queue between the packet builder and the byte emitter
// ----------------------------------------------------------------------------
module tpbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tpbp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count over depth");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - CW'(1))
      else $error("queue count missed a pop");

endmodule

FILE: rtl/tpbp_back.sv
// ----------------------------------------------------------------------------
// tpbp_back
// merges packets into the byte stream and emits completed bytes
// ----------------------------------------------------------------------------
module tpbp_back #(
   parameter int PKT_W = 76
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [PKT_W-1:0]        pop_pkt,
   input  tpbp_pkg::entry_ctl_type pop_ctl,
   tpbp_rsp_if.source              rsp
);

   localparam int BW       = tpbp_pkg::BITCNT_W;
   localparam int STREAM_W = ((PKT_W + 7) / 8 + 1) * 8;

   logic [STREAM_W-1:0] stream_ff, stream_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [1:0]          status_ff, status_in;
   logic [7:0]          carry_ff, carry_in;
   logic [2:0]          off_ff, off_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic [STREAM_W-1:0] merged;
   logic [BW-1:0]       total;
   logic [3:0]          good;
   logic [2:0]          rest;
   logic [7:0]          tail;
   logic                emit, pop;

   assign merged = (STREAM_W'(pop_pkt) << off_ff) | STREAM_W'(carry_ff);
   assign total  = BW'(off_ff) + pop_ctl.bitcnt;
   assign good   = (total[BW-1:3] > 4'(tpbp_pkg::MAX_BYTES)) ? 4'(tpbp_pkg::MAX_BYTES)
                                                              : 4'(total[BW-1:3]);
   assign rest   = total[2:0];
   assign tail   = 8'(merged >> {good, 3'b000}) & 8'((9'd1 << rest) - 9'd1);

   assign emit      = (cnt_ff != '0) && (!valid_ff || rsp.ready);
   assign pop_ready = (cnt_ff == '0) || (cnt_ff == 4'd1 && emit);
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      stream_in     = stream_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      carry_in      = carry_ff;
      off_in        = off_ff;
      valid_in      = valid_ff && !rsp.ready;
      byte_in       = byte_ff;
      last_in       = last_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         valid_in      = 1'b1;
         byte_in       = stream_ff[7:0];
         last_in       = (cnt_ff == 4'd1);
         rsp_status_in = status_ff;
         stream_in     = stream_ff >> 8;
         cnt_in        = cnt_ff - 4'd1;
      end
      if (pop) begin
         if (pop_ctl.flush) begin
            stream_in = STREAM_W'(carry_ff);
            cnt_in    = 4'd1;
            status_in = tpbp_pkg::ST_OK;
            carry_in  = '0;
            off_in    = '0;
         end else if (pop_ctl.status != tpbp_pkg::ST_OK) begin
            stream_in = '0;
            cnt_in    = 4'd1;
            status_in = pop_ctl.status;
         end else begin
            stream_in = merged;
            cnt_in    = good;
            status_in = tpbp_pkg::ST_OK;
            carry_in  = tail;
            off_in    = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      stream_ff     <= stream_in;
      status_ff     <= status_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         carry_ff <= '0;
         off_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         carry_ff <= carry_in;
         off_ff   <= off_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.last     = last_ff;
   assign rsp.status   = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(tpbp_pkg::MAX_BYTES))
      else $error("byte count over limit");
   assert property (@(posedge clock) disable iff (reset)
      pop && pop_ctl.flush |=> off_ff == '0 && carry_ff == '0)
      else $error("flush left pending bits");
   assert property (@(posedge clock) disable iff (reset)
      (carry_ff & ~8'((9'd1 << off_ff) - 9'd1)) == '0)
      else $error("carry holds bits above offset");

endmodule

FILE: rtl/trace_packet_bit_packer.sv
// ----------------------------------------------------------------------------
// trace_packet_bit_packer
// packs trace packets least significant bit first into a byte stream
// ----------------------------------------------------------------------------
// req carries one packet or flush item, rsp carries the completed bytes of
// each item, with last marking the final byte of that item. csr_we writes the
// wide address flag (index 0) or map compression (index 1) from csr_wdata.
// An item is built in the cycle it is accepted and queued in a two-entry
// queue; the emitter then sends one byte per cycle while rsp is ready, and
// a packet completes up to 10 bytes. The first byte passes the queue, the
// stream register and the rsp byte register before it is valid on rsp.
// Items whose bits stay pending give no byte; a flush always gives one byte
// with the pending bits. Error items give one zero byte with a status code
// and leave the pending bits alone. Reset clears the pending bits, the queue
// and both registers. When rsp stalls, the emitter holds its byte and the
// queue fills, after which req.ready drops.
// ----------------------------------------------------------------------------
module trace_packet_bit_packer #(
   parameter int ADDR_WIDTH  = tpbp_pkg::ADDR_WIDTH_DEF,
   parameter int CAUSE_WIDTH = tpbp_pkg::CAUSE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tpbp_req_if.sink    req_bus,
   tpbp_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   localparam int PKT_W = 44 + ADDR_WIDTH;
   localparam int ENT_W = PKT_W + $bits(tpbp_pkg::entry_ctl_type);

   logic wide_addr_ff, wide_addr_in;
   logic compress_ff, compress_in;

   logic                    push_valid, push_ready, pop_valid, pop_ready;
   logic [PKT_W-1:0]        push_pkt, pop_pkt;
   tpbp_pkg::entry_ctl_type push_ctl, pop_ctl;
   logic [ENT_W-1:0]        pop_data;

   always_comb begin
      wide_addr_in = wide_addr_ff;
      compress_in  = compress_ff;
      if (csr_we) begin
         case (csr_index)
            tpbp_pkg::CSR_WIDE_ADDR:    wide_addr_in = csr_wdata;
            tpbp_pkg::CSR_COMPRESS_MAP: compress_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_addr_ff <= 1'b0;
         compress_ff  <= 1'b0;
      end else begin
         wide_addr_ff <= wide_addr_in;
         compress_ff  <= compress_in;
      end
   end

   tpbp_front #(
      .ADDR_WIDTH  (ADDR_WIDTH),
      .CAUSE_WIDTH (CAUSE_WIDTH),
      .PKT_W       (PKT_W)
   ) u_front (
      .req          (req_bus),
      .wide_addr    (wide_addr_ff),
      .compress_map (compress_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_pkt     (push_pkt),
      .push_ctl     (push_ctl)
   );

   tpbp_fifo #(
      .WIDTH (ENT_W),
      .DEPTH (tpbp_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_ctl, push_pkt}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_pkt = pop_data[PKT_W-1:0];
   assign pop_ctl = pop_data[ENT_W-1:PKT_W];

   tpbp_back #(
      .PKT_W (PKT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_pkt   (pop_pkt),
      .pop_ctl   (pop_ctl),
      .rsp       (rsp_bus)
   );

endmodule
